@@ hdl/frnf_pkg.sv @@
package frnf_pkg;

  localparam int MaxParticlesDefault = 64;
  localparam int CoordWidth = 24;
  localparam int RadiusWidth = 52;
  localparam int DimWidth = 2;
  localparam int MaskWidth = 64;
  localparam int IndexWidth = 6;
  localparam int CfgAddrWidth = 1;
  localparam int CfgDataWidth = 52;

  localparam logic [CfgAddrWidth-1:0] RegRadiusSquared = 1'd0;
  localparam logic [CfgAddrWidth-1:0] RegDimensions = 1'd1;

  typedef struct packed {
    logic signed [CoordWidth-1:0] pos_x;
    logic signed [CoordWidth-1:0] pos_y;
    logic signed [CoordWidth-1:0] pos_z;
    logic                         last_particle;
  } in_item_t;

  typedef struct packed {
    logic [IndexWidth-1:0] particle_index;
    logic [MaskWidth-1:0]  neighbor_mask;
    logic [MaskWidth-1:0]  second_mask;
    logic                  overflow;
    logic                  last_result;
  } out_item_t;

endpackage

@@ hdl/frnf_ram.sv @@
module frnf_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/fixed_radius_neighbor_finder_top.sv @@
// Fixed-radius neighbor finder.
//
// Input channel (in_valid, in_stall, in_item): one particle position per item.
// Items are stored in load order; loads beyond MAX_PARTICLES are dropped and
// flagged. The item with last_particle set starts the search over the set.
// Output channel (out_valid, out_stall, out_item): one item per loaded
// particle, in index order, carrying its neighbor and second-neighbor masks.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written by the user
// only while idle; the block itself does not enforce this.
//
// For each particle the pair pass fetches its reference position, reads
// every loaded position, drains the distance pipeline and writes one row;
// the OR pass fetches its own row, reads the rows, folds the last, emits.
// While the receiver stalls, the next particle's OR pass runs on and its
// result waits for the output register. Once the last result is loaded the
// input channel opens again, even while that item still waits.
//
// Reset clears the fill count, the drop flag and all control state; the
// memories are not cleared, since only entries written in this run are read.
// The input channel is stalled while a search is in progress.
module fixed_radius_neighbor_finder_top
  import frnf_pkg::*;
#(
  parameter int MAX_PARTICLES = MaxParticlesDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_item,
  input  logic                    cfg_we,
  input  logic [CfgAddrWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [2:0] {
    S_LOAD, S_PAIR_ROW, S_PAIR_READ, S_PAIR_ACC, S_PAIR_WRITE,
    S_OR_READ, S_OR_ACC, S_EMIT
  } state_t;

  state_t state;
  logic [RadiusWidth-1:0] radius_squared;
  logic [DimWidth-1:0]    dimensions;
  logic [CW-1:0]          loaded_count;
  logic                   dropped_flag;
  logic [AW-1:0]          row_i;
  logic [CW-1:0]          col_j;     // read pointer, counts to n
  logic                   pipe_v;    // a memory read is in flight
  logic [AW-1:0]          pipe_j;
  logic [MaskWidth-1:0]   row_acc;
  logic [MaskWidth-1:0]   own_row;
  logic                   own_ok;
  logic signed [CoordWidth-1:0] ref_x, ref_y, ref_z;

  // Memory ports.
  logic                  pos_we;
  logic [AW-1:0]         pos_waddr, pos_raddr;
  logic [CoordWidth-1:0] rd_x, rd_y, rd_z;
  logic                  adj_we;
  logic [AW-1:0]         adj_raddr;
  logic [MaskWidth-1:0]  rd_row;

  frnf_ram #(.Width(CoordWidth), .Depth(MAX_PARTICLES)) u_x (
    .clk, .we(pos_we), .waddr(pos_waddr), .wdata(in_item.pos_x),
    .raddr(pos_raddr), .rdata(rd_x));
  frnf_ram #(.Width(CoordWidth), .Depth(MAX_PARTICLES)) u_y (
    .clk, .we(pos_we), .waddr(pos_waddr), .wdata(in_item.pos_y),
    .raddr(pos_raddr), .rdata(rd_y));
  frnf_ram #(.Width(CoordWidth), .Depth(MAX_PARTICLES)) u_z (
    .clk, .we(pos_we), .waddr(pos_waddr), .wdata(in_item.pos_z),
    .raddr(pos_raddr), .rdata(rd_z));
  frnf_ram #(.Width(MaskWidth), .Depth(MAX_PARTICLES)) u_adj (
    .clk, .we(adj_we), .waddr(row_i), .wdata(row_acc),
    .raddr(adj_raddr), .rdata(rd_row));

  logic in_acc;
  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign pos_we   = in_acc && (loaded_count < CW'(MAX_PARTICLES));
  assign pos_waddr = loaded_count[AW-1:0];
  assign adj_we   = (state == S_PAIR_WRITE);

  // Read address: the pointer during sweeps, the reference row otherwise.
  // The first OR cycle of a particle fetches its own row.
  logic sweeping;
  assign sweeping  = (state == S_PAIR_READ) || (state == S_OR_READ);
  assign pos_raddr = sweeping ? col_j[AW-1:0] : row_i;
  assign adj_raddr = ((state == S_OR_READ) && own_ok) ? col_j[AW-1:0] : row_i;

  // Distance pipeline: differences are formed from registered reads, squared
  // in the next stage, summed and compared in the stage after.
  logic                 d_v, s_v, c_v;
  logic [AW-1:0]        d_j, s_j, c_j;
  logic signed [CoordWidth:0] dx, dy, dz;
  logic [2*CoordWidth+1:0]  sqx, sqy, sqz;
  logic                 hit;

  always_ff @(posedge clk) begin
    dx <= {rd_x[CoordWidth-1], rd_x} - {ref_x[CoordWidth-1], ref_x};
    dy <= {rd_y[CoordWidth-1], rd_y} - {ref_y[CoordWidth-1], ref_y};
    dz <= {rd_z[CoordWidth-1], rd_z} - {ref_z[CoordWidth-1], ref_z};
    sqx <= (dimensions >= 2'd1) ?
           $unsigned((2*CoordWidth+2)'(dx) * (2*CoordWidth+2)'(dx)) : '0;
    sqy <= (dimensions >= 2'd2) ?
           $unsigned((2*CoordWidth+2)'(dy) * (2*CoordWidth+2)'(dy)) : '0;
    sqz <= (dimensions >= 2'd3) ?
           $unsigned((2*CoordWidth+2)'(dz) * (2*CoordWidth+2)'(dz)) : '0;
    hit <= ((RadiusWidth+2)'(sqx) + (RadiusWidth+2)'(sqy) + (RadiusWidth+2)'(sqz))
           < (RadiusWidth+2)'(radius_squared);
    d_j <= pipe_j;
    s_j <= d_j;
    c_j <= s_j;
  end

  logic [CW-1:0] n;
  assign n = loaded_count;
  logic pending;
  assign pending = pipe_v || d_v || s_v || c_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      radius_squared <= '0;
      dimensions <= 2'd2;
      loaded_count <= '0;
      dropped_flag <= 1'b0;
      out_valid <= 1'b0;
      pipe_v <= 1'b0;
      d_v <= 1'b0;
      s_v <= 1'b0;
      c_v <= 1'b0;
      row_i <= '0;
      col_j <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegRadiusSquared: radius_squared <= cfg_data[RadiusWidth-1:0];
          RegDimensions:    dimensions <= cfg_data[DimWidth-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      pipe_v <= 1'b0;
      pipe_j <= col_j[AW-1:0];
      d_v <= pipe_v && (state == S_PAIR_READ || state == S_PAIR_ACC);
      s_v <= d_v;
      c_v <= s_v;
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (pos_we) loaded_count <= loaded_count + 1'b1;
            else dropped_flag <= 1'b1;
            if (in_item.last_particle) begin
              row_i <= '0;
              if (pos_we || loaded_count != '0) state <= S_PAIR_ROW;
              else begin
                dropped_flag <= 1'b0;
              end
            end
          end
        end
        S_PAIR_ROW: begin
          // The reference position read is requested here and captured in S_PAIR_READ.
          state <= S_PAIR_READ;
          col_j <= '0;
          row_acc <= '0;
        end
        S_PAIR_READ: begin
          if (col_j == '0 && !pipe_v) begin
            ref_x <= rd_x;
            ref_y <= rd_y;
            ref_z <= rd_z;
          end
          if (col_j < n) begin
            pipe_v <= 1'b1;
            col_j <= col_j + 1'b1;
          end else begin
            state <= S_PAIR_ACC;
          end
          if (c_v && hit && c_j != row_i) row_acc[c_j] <= 1'b1;
        end
        S_PAIR_ACC: begin
          if (c_v && hit && c_j != row_i) row_acc[c_j] <= 1'b1;
          if (!pending) state <= S_PAIR_WRITE;
        end
        S_PAIR_WRITE: begin
          if (CW'(row_i) + 1'b1 == n) begin
            row_i <= '0;
            state <= S_OR_READ;
            col_j <= '0;
            own_ok <= 1'b0;
            row_acc <= '0;
          end else begin
            row_i <= row_i + 1'b1;
            state <= S_PAIR_ROW;
          end
        end
        S_OR_READ: begin
          // First cycle requests this particle's own row; it is captured next.
          if (!own_ok) begin
            own_ok <= 1'b1;
            pipe_v <= 1'b0;
          end else begin
            if (!pipe_v && col_j == '0 && row_acc == '0) own_row <= rd_row;
            if (col_j < n) begin
              pipe_v <= 1'b1;
              col_j <= col_j + 1'b1;
            end else begin
              state <= S_OR_ACC;
            end
          end
          if (pipe_v && own_row[pipe_j]) row_acc <= row_acc | rd_row;
        end
        S_OR_ACC: begin
          if (pipe_v && own_row[pipe_j]) row_acc <= row_acc | rd_row;
          if (!pipe_v) state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_item.particle_index <= IndexWidth'(row_i);
            out_item.neighbor_mask <= own_row;
            out_item.second_mask <= row_acc & ~own_row &
                                    ~(MaskWidth'(1) << row_i);
            out_item.overflow <= dropped_flag;
            out_item.last_result <= (CW'(row_i) + 1'b1 == n);
            if (CW'(row_i) + 1'b1 == n) begin
              loaded_count <= '0;
              dropped_flag <= 1'b0;
              row_i <= '0;
              state <= S_LOAD;
            end else begin
              row_i <= row_i + 1'b1;
              col_j <= '0;
              own_ok <= 1'b0;
              row_acc <= '0;
              state <= S_OR_READ;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

@@ hdl/frnf_checker.sv @@
module frnf_checker
  import frnf_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_valid && !in_stall |-> out_item.last_result)
    else $error("input taken while more results of the set are due");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_item.last_result ##1 out_valid
    |-> out_item.particle_index == $past(out_item.particle_index) + 6'd1)
    else $error("result index skipped");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind fixed_radius_neighbor_finder_top frnf_checker u_frnf_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_item);
